>>> src/battery_telemetry_frame_builder_core_macros.svh
// ----------------------------------------------------------------------------
// Battery telemetry frame builder - assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BATTERY_TELEMETRY_FRAME_BUILDER_CORE_MACROS_SVH
`define BATTERY_TELEMETRY_FRAME_BUILDER_CORE_MACROS_SVH

// Condition that must hold at every clock edge outside reset
`define BTFB_ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Condition that must hold in the cycle after the trigger
`define BTFB_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/btfb_pkg.sv
// ----------------------------------------------------------------------------
// Battery telemetry frame builder - package
// Frame constants, byte position codes and the converted item type.
// ----------------------------------------------------------------------------
package btfb_pkg;

   // Fixed frame bytes
   localparam logic [7:0] ADDR_BYTE = 8'hC8;
   localparam logic [7:0] LEN_BYTE  = 8'h08;
   localparam logic [7:0] TYPE_BYTE = 8'h08;
   localparam logic [7:0] CAP_BYTE  = 8'h00;

   // CRC-8 polynomial and top bit
   localparam logic [7:0] CRC_POLY = 8'hD5;
   localparam logic [7:0] CRC_TOP  = 8'h80;

   // Byte position within the frame, in transmit order
   typedef enum logic [3:0] {
      POS_ADDR   = 4'd0,
      POS_LEN    = 4'd1,
      POS_TYPE   = 4'd2,
      POS_VOLT_H = 4'd3,
      POS_VOLT_L = 4'd4,
      POS_CURR_H = 4'd5,
      POS_CURR_L = 4'd6,
      POS_CAP    = 4'd7,
      POS_REMAIN = 4'd8,
      POS_CRC    = 4'd9
   } frame_pos_type;

   // One item after conversion to tenths
   typedef struct packed {
      logic [15:0] volt_tenths;
      logic [15:0] curr_tenths;
      logic [7:0]  remaining_pct;
   } item_type;

endpackage

>>> src/btfb_frame_tx.sv
// ----------------------------------------------------------------------------
// Battery telemetry frame builder - frame transmitter
// Sends one converted item as a ten-byte frame, one beat per byte, with the
// CRC-8 built up as the payload bytes go out.
// ----------------------------------------------------------------------------
module btfb_frame_tx (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   output logic              item_take,
   input  btfb_pkg::item_type item,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,   // frame_byte [7:0]
   output logic              rsp_tlast    // last_byte
);
   import btfb_pkg::*;

   // One CRC-8 step over a byte, MSB first
   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if ((c & CRC_TOP) != 8'h00) begin
            c = (c << 1) ^ CRC_POLY;
         end else begin
            c = c << 1;
         end
      end
      return c;
   endfunction

   item_type      item_ff, item_in;
   frame_pos_type pos_ff, pos_in;
   logic          busy_ff, busy_in;
   logic [7:0]    crc_ff, crc_in;
   logic          rsp_tvalid_ff, rsp_tvalid_in;
   logic [7:0]    rsp_tdata_ff, rsp_tdata_in;
   logic          rsp_tlast_ff, rsp_tlast_in;

   logic       out_free;
   logic       emit;
   logic       load;
   logic [7:0] cur_byte;

   // Select the byte at the current position
   always_comb begin
      unique case (pos_ff)
         POS_ADDR:   cur_byte = ADDR_BYTE;
         POS_LEN:    cur_byte = LEN_BYTE;
         POS_TYPE:   cur_byte = TYPE_BYTE;
         POS_VOLT_H: cur_byte = item_ff.volt_tenths[15:8];
         POS_VOLT_L: cur_byte = item_ff.volt_tenths[7:0];
         POS_CURR_H: cur_byte = item_ff.curr_tenths[15:8];
         POS_CURR_L: cur_byte = item_ff.curr_tenths[7:0];
         POS_CAP:    cur_byte = CAP_BYTE;
         POS_REMAIN: cur_byte = item_ff.remaining_pct;
         POS_CRC:    cur_byte = crc_ff;
         default:    cur_byte = 8'h00;
      endcase
   end

   // Advance the frame whenever the output register can take a beat
   always_comb begin
      out_free  = !rsp_tvalid_ff || rsp_tready;
      emit      = busy_ff && out_free;
      load      = item_valid && (!busy_ff || (emit && pos_ff == POS_CRC));
      item_take = load;

      item_in       = item_ff;
      pos_in        = pos_ff;
      busy_in       = busy_ff;
      crc_in        = crc_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tlast_in  = rsp_tlast_ff;

      if (emit) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = cur_byte;
         rsp_tlast_in  = (pos_ff == POS_CRC);
         if (pos_ff inside {[POS_TYPE:POS_REMAIN]}) begin
            crc_in = crc8_step(crc_ff, cur_byte);
         end
         if (pos_ff == POS_CRC) begin
            pos_in  = POS_ADDR;
            busy_in = 1'b0;
         end else begin
            pos_in = frame_pos_type'(pos_ff + 4'd1);
         end
      end

      // Start the next frame straight after the CRC beat
      if (load) begin
         item_in = item;
         pos_in  = POS_ADDR;
         busy_in = 1'b1;
         crc_in  = 8'h00;
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= POS_ADDR;
         busy_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         pos_ff        <= pos_in;
         busy_ff       <= busy_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // Hold payload
   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      crc_ff       <= crc_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tlast_ff <= rsp_tlast_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

`include "battery_telemetry_frame_builder_core_macros.svh"

   `BTFB_ASSERT_NEXT(a_wrap_after_crc, emit && pos_ff == POS_CRC, pos_ff == POS_ADDR, "frame did not wrap after CRC beat")
   `BTFB_ASSERT_NEXT(a_no_gap_in_frame, rsp_tvalid && rsp_tready && !rsp_tlast, rsp_tvalid, "gap inside a frame")
   `BTFB_ASSERT_NEXT(a_pos_holds_on_stall, busy_ff && !out_free, $stable(pos_ff) && $stable(crc_ff), "frame advanced during stall")
   `BTFB_ASSERT_ALWAYS(a_idle_at_start, busy_ff || pos_ff == POS_ADDR, "idle transmitter left mid-frame")

endmodule

>>> src/battery_telemetry_frame_builder_core.sv
// ----------------------------------------------------------------------------
// Battery telemetry frame builder - top level
// Takes voltage, current and remaining charge, converts the readings to
// tenths and sends a ten-byte telemetry frame with a CRC-8 trailer.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Beat                                   Handshake
//   req_*    in         voltage_q4, current_q4, remaining_pct  tvalid/tready
//   rsp_*    out        frame_byte (tdata), last_byte (tlast)  tvalid/tready
//
// Each item becomes ten frame bytes: the result channel carries one frame byte per
// beat, so the frame transmitter sets the pace.
// An input register accepts the next item while the current frame is sent,
// and frames follow one another with no idle beat.
// Reset is synchronous and active high; it empties both registers.
// A stall on rsp_tready freezes the frame; req_tready drops while the input
// register is occupied.
module battery_telemetry_frame_builder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // voltage_q4 [15:0], current_q4 [31:16],
                                    // remaining_pct [39:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // frame_byte [7:0]
   output logic        rsp_tlast    // last_byte
);
   import btfb_pkg::*;

   // Convert Q12.4 to tenths: (x * 10) >> 4, truncated
   function automatic logic [15:0] to_tenths(input logic [15:0] q4);
      logic [19:0] prod;
      prod = ({4'b0, q4} << 3) + ({4'b0, q4} << 1);
      return prod[19:4];
   endfunction

   logic        hold_valid_ff, hold_valid_in;
   logic [39:0] hold_data_ff, hold_data_in;

   logic     item_take;
   item_type item;

   assign req_tready = !hold_valid_ff;

   // Fill the input register on a beat, drop it when the transmitter takes it
   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_data_in  = hold_data_ff;
      if (item_take) begin
         hold_valid_in = 1'b0;
      end
      if (req_tvalid && req_tready) begin
         hold_valid_in = 1'b1;
         hold_data_in  = req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_data_ff <= hold_data_in;
   end

   // Scale the held readings for the transmitter
   always_comb begin
      item.volt_tenths   = to_tenths(hold_data_ff[15:0]);
      item.curr_tenths   = to_tenths(hold_data_ff[31:16]);
      item.remaining_pct = hold_data_ff[39:32];
   end

   btfb_frame_tx u_frame_tx (
      .clock      (clock),
      .reset      (reset),
      .item_valid (hold_valid_ff),
      .item_take  (item_take),
      .item       (item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> test/battery_telemetry_frame_builder_core_test.sv
// ----------------------------------------------------------------------------
// Battery telemetry frame builder - testbench
// Drives voltage, current and charge readings into the core and checks every
// frame byte it sends against a local frame predictor. A short table of
// corner readings comes first, then randomised readings, with random bursts
// of idle cycles on both streams except in a middle and a closing quiet stretch.
// ----------------------------------------------------------------------------
module battery_telemetry_frame_builder_core_test;
   import btfb_pkg::*;

   localparam int FRAME_BYTES    = 10;
   localparam int TABLE_ROWS     = 14;
   localparam int RANDOM_READS   = 246;
   localparam int QUIET_TAIL     = 40;
   localparam int SETTLE_CYCLES  = 30;

   typedef logic [FRAME_BYTES-1:0][7:0] frame_type;

   // One expected beat on the frame stream
   typedef struct {
      logic [7:0]    data;
      logic          last;
      frame_pos_type pos;
      int            frame_no;
   } frame_beat_type;

   // One reading of the corner table; pinned rows carry hand-worked tenths
   typedef struct {
      logic [15:0] volt_q4;
      logic [15:0] curr_q4;
      logic [7:0]  remain;
      bit          pinned;
      logic [15:0] volt_tenths;
      logic [15:0] curr_tenths;
   } reading_row_type;

   reading_row_type corner_readings [TABLE_ROWS] = '{
      // volt     curr      pct    pin  volt/10   curr/10
      '{16'h0000, 16'h0000, 8'h00, 1'b1, 16'h0000, 16'h0000},  // empty pack
      '{16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, 16'h9FFF, 16'h9FFF},  // full scale
      '{16'hFFFF, 16'h0000, 8'h00, 1'b1, 16'h9FFF, 16'h0000},
      '{16'h0000, 16'hFFFF, 8'hFF, 1'b1, 16'h0000, 16'h9FFF},
      '{16'h0001, 16'h000F, 8'h01, 1'b1, 16'h0000, 16'h0009},  // truncation
      '{16'h0002, 16'h0010, 8'h7F, 1'b1, 16'h0001, 16'h000A},
      '{16'h8000, 16'h8000, 8'h80, 1'b1, 16'h5000, 16'h5000},  // top bit only
      '{16'h00A0, 16'h0000, 8'h64, 1'b1, 16'h0064, 16'h0000},  // ten volts
      '{16'hFFF0, 16'h000F, 8'h00, 1'b1, 16'h9FF6, 16'h0009},
      '{16'h5555, 16'hAAAA, 8'h55, 1'b0, 16'h0000, 16'h0000},
      '{16'hAAAA, 16'h5555, 8'hAA, 1'b0, 16'h0000, 16'h0000},
      '{16'h7FFF, 16'h0001, 8'hFE, 1'b0, 16'h0000, 16'h0000},
      '{16'h1234, 16'h4321, 8'h64, 1'b0, 16'h0000, 16'h0000},
      '{16'h0C9A, 16'h00F3, 8'h3C, 1'b0, 16'h0000, 16'h0000}
   };

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;   // voltage_q4 [15:0], current_q4 [31:16],
                             // remaining_pct [39:32]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // frame_byte [7:0]
   logic        rsp_tlast;   // last_byte

   frame_beat_type pending_beats [$];
   frame_type      next_frame;
   bit             idle_on;
   int             mismatch_count;
   int             readings_sent;
   int             frames_seen;
   int             bytes_checked;

   battery_telemetry_frame_builder_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Convert a Q12.4 reading to tenths, truncated
   function automatic logic [15:0] tenths_of(logic [15:0] q4);
      logic [19:0] scaled;
      scaled = {4'd0, q4} * 20'd10;
      return scaled[19:4];
   endfunction

   // Advance the CRC-8 by one byte, MSB first
   function automatic logic [7:0] crc8_update(logic [7:0] crc, logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++)
         c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      return c;
   endfunction

   // Assemble the telemetry frame for converted readings
   function automatic frame_type telemetry_frame(logic [15:0] volt_tenths,
                                                 logic [15:0] curr_tenths,
                                                 logic [7:0] remain);
      frame_type  f;
      logic [7:0] crc;
      f[POS_ADDR]   = ADDR_BYTE;
      f[POS_LEN]    = LEN_BYTE;
      f[POS_TYPE]   = TYPE_BYTE;
      f[POS_VOLT_H] = volt_tenths[15:8];
      f[POS_VOLT_L] = volt_tenths[7:0];
      f[POS_CURR_H] = curr_tenths[15:8];
      f[POS_CURR_L] = curr_tenths[7:0];
      f[POS_CAP]    = CAP_BYTE;
      f[POS_REMAIN] = remain;
      crc = 8'h00;
      for (int k = POS_TYPE; k < POS_CRC; k++)
         crc = crc8_update(crc, f[k]);
      f[POS_CRC] = crc;
      return f;
   endfunction

   task automatic report_mismatch(string what, int frame_no, logic [7:0] want,
                                  logic [7:0] got);
      $display("MISMATCH frame %0d %s: expected %02h, got %02h",
               frame_no, what, want, got);
      mismatch_count++;
   endtask

   // Mostly uniform, with a fair share of zero, full scale, tiny and single-bit values
   function automatic logic [15:0] random_reading();
      case ($urandom_range(0, 7))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'($urandom_range(0, 31));
         3:       return 16'h0001 << $urandom_range(0, 15);
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // Present one reading from a falling edge; return at the falling edge after acceptance
   task automatic send_reading(logic [15:0] volt_q4, logic [15:0] curr_q4,
                               logic [7:0] remain, frame_type frame);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      next_frame <= frame;
      req_tvalid <= 1'b1;
      req_tdata  <= {remain, curr_q4, volt_q4};
      do @(posedge clock); while (!req_tready);
      readings_sent++;
      @(negedge clock);
   endtask

   // Stall the frame stream in random bursts while idling is on
   initial begin
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // Queue the frame of each accepted reading, then check each frame beat
   always @(posedge clock) begin
      frame_beat_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            for (int k = 0; k < FRAME_BYTES; k++) begin
               want.data     = next_frame[k];
               want.last     = (k == POS_CRC);
               want.pos      = frame_pos_type'(k);
               want.frame_no = readings_sent;
               pending_beats.push_back(want);
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_beats.size() == 0) begin
               report_mismatch("unexpected beat", frames_seen, 8'hxx, rsp_tdata);
            end else begin
               want = pending_beats.pop_front();
               if (rsp_tdata !== want.data)
                  report_mismatch($sformatf("%s data", want.pos.name()),
                                  want.frame_no, want.data, rsp_tdata);
               if (rsp_tlast !== want.last)
                  report_mismatch($sformatf("%s last", want.pos.name()),
                                  want.frame_no, 8'(want.last), 8'(rsp_tlast));
               if (want.last)
                  frames_seen++;
               bytes_checked++;
            end
         end
      end
   end

   // Give up if the frames stop coming
   initial begin
      #(8 * 600000);
      $display("Timeout with %0d frame bytes still due", pending_beats.size());
      $display("Verification failed");
      $finish;
   end

   initial begin
      logic [15:0] volt_q4;
      logic [15:0] curr_q4;
      logic [7:0]  remain;
      frame_type   frame;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      next_frame     = '0;
      idle_on        = 1'b1;
      mismatch_count = 0;
      readings_sent  = 0;
      frames_seen    = 0;
      bytes_checked  = 0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Corner table; pinned rows use the hand-worked tenths
      for (int r = 0; r < TABLE_ROWS; r++) begin
         if (corner_readings[r].pinned)
            frame = telemetry_frame(corner_readings[r].volt_tenths,
                                    corner_readings[r].curr_tenths,
                                    corner_readings[r].remain);
         else
            frame = telemetry_frame(tenths_of(corner_readings[r].volt_q4),
                                    tenths_of(corner_readings[r].curr_q4),
                                    corner_readings[r].remain);
         send_reading(corner_readings[r].volt_q4, corner_readings[r].curr_q4,
                      corner_readings[r].remain, frame);
      end

      // Random readings; quiet stretches in the middle and at the tail
      for (int n = 0; n < RANDOM_READS; n++) begin
         idle_on = !((n >= 80 && n < 120) || n >= RANDOM_READS - QUIET_TAIL);
         volt_q4 = random_reading();
         curr_q4 = random_reading();
         remain  = 8'($urandom_range(0, 255));
         frame   = telemetry_frame(tenths_of(volt_q4), tenths_of(curr_q4), remain);
         send_reading(volt_q4, curr_q4, remain, frame);
      end
      req_tvalid <= 1'b0;

      // Drain outstanding frames, then watch for stray beats
      while (pending_beats.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d readings (corner table and random), %0d frames and %0d bytes checked",
               readings_sent, frames_seen, bytes_checked);
      $display("Idle bursts on both streams, quiet stretches without; %0d mismatches",
               mismatch_count);
      if (mismatch_count == 0 && pending_beats.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
